FILE: rtl/core/ifp_pkg.sv
// Shared types, character codes and precedence decode for the infix-to-postfix converter.
// Used by ifp_ctrl, ifp_datapath and infix_to_postfix_converter; depends on nothing.
package ifp_pkg;

    localparam logic [7:0] C_CARET   = 8'h5E;
    localparam logic [7:0] C_STAR    = 8'h2A;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_MINUS   = 8'h2D;
    localparam logic [7:0] C_LPAREN  = 8'h28;
    localparam logic [7:0] C_RPAREN  = 8'h29;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7A;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_Z = 8'h5A;

    typedef enum logic [1:0] {
        EMIT_CHAR = 2'd0,
        EMIT_TOP  = 2'd1,
        EMIT_ZERO = 2'd2
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      push;
        logic      pop;
        logic      emit;
        t_emit_sel sel;
        logic      term;
        logic      ovf;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_end;
        logic is_letter;
        logic is_lparen;
        logic is_rparen;
        logic empty;
        logic full;
        logic top_lparen;
        logic pop_ok;
        logic can_emit;
    } t_ctrl_status;

    // Precedence rank: 0 for anything that is not an arithmetic operator.
    function automatic logic [1:0] prec_of(input logic [7:0] ch);
        logic [1:0] p;
        begin
            p = 2'd0;
            if (ch == C_CARET) begin
                p = 2'd3;
            end else if (ch == C_STAR || ch == C_SLASH) begin
                p = 2'd2;
            end else if (ch == C_PLUS || ch == C_MINUS) begin
                p = 2'd1;
            end
            return p;
        end
    endfunction

endpackage

FILE: rtl/core/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter (shunting-yard scheme).
// Instantiates ifp_ctrl and ifp_datapath; depends on ifp_pkg.
//
// One request carries one expression character (or an end mark); it is taken when the
// block is idle and then worked through one result per step, plus a step for a push or
// a discarded '(' that produces nothing; no new request is taken until it is done.
// The stack sits in a single memory whose read port prefetches the top entry each
// cycle, which sets the pace of one pop per cycle while the output stage is free.
// Results leave through a registered output stage; the block stalls while that stage
// is full and not taken. A push onto a full stack drops the character and yields one
// result with the overflow flag set.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_terminator,
    output logic       o_overflow
);

    ifp_pkg::t_ctrl_cmd    cmd;
    ifp_pkg::t_ctrl_status status;

    ifp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ifp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_char     (i_in_char),
        .i_end_of_expr (i_end_of_expr),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_char    (o_out_char),
        .o_terminator  (o_terminator),
        .o_overflow    (o_overflow)
    );

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in one cycle");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result written over an untaken one");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after a request was taken");

    a_overflow_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ovf |-> (status.full && !cmd.push))
        else $error("overflow reported with room on the stack");

endmodule

FILE: rtl/core/ifp_ctrl.sv
// Sequencer for the infix-to-postfix converter: takes a request, then pops,
// pushes and emits one step per cycle when not stalled. Depends on ifp_pkg.
module ifp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ifp_pkg::t_ctrl_status i_status,
    output ifp_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = ifp_pkg::EMIT_CHAR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                if (i_status.can_emit) begin
                    if (i_status.is_end) begin
                        o_cmd.emit = 1'b1;
                        if (!i_status.empty) begin
                            o_cmd.sel = ifp_pkg::EMIT_TOP;
                            o_cmd.pop = 1'b1;
                        end else begin
                            o_cmd.sel  = ifp_pkg::EMIT_ZERO;
                            o_cmd.term = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else if (i_status.is_letter) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else if (i_status.is_rparen) begin
                        if (!i_status.empty && !i_status.top_lparen) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.sel  = ifp_pkg::EMIT_TOP;
                            o_cmd.pop  = 1'b1;
                        end else begin
                            o_cmd.pop = !i_status.empty;
                            n_state   = S_IDLE;
                        end
                    end else if (!i_status.is_lparen && !i_status.empty
                                 && i_status.pop_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = ifp_pkg::EMIT_TOP;
                        o_cmd.pop  = 1'b1;
                    end else if (i_status.full) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = ifp_pkg::EMIT_ZERO;
                        o_cmd.ovf  = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/ifp_datapath.sv
// Datapath of the infix-to-postfix converter: request latch, operator stack
// memory with prefetched top entry, and the result register. Depends on ifp_pkg.
module ifp_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_in_char,
    input  logic                  i_end_of_expr,
    input  logic                  i_out_ready,
    input  ifp_pkg::t_ctrl_cmd    i_cmd,
    output ifp_pkg::t_ctrl_status o_status,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_char,
    output logic                  o_terminator,
    output logic                  o_overflow
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [7:0]    r_mem [STACK_DEPTH];
    logic [7:0]    r_ch;
    logic          r_end;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] top_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    r_top;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_term;
    logic          r_ovf;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
        top_idx = (n_count == '0) ? '0 : (n_count - CW'(1));
    end

    assign rd_addr = top_idx[AW-1:0];
    assign wr_addr = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= r_ch;
        end
        if (i_cmd.push && wr_addr == rd_addr) begin
            r_top <= r_ch;
        end else begin
            r_top <= r_mem[rd_addr];
        end
        if (i_cmd.load) begin
            r_ch  <= i_in_char;
            r_end <= i_end_of_expr;
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.sel)
                ifp_pkg::EMIT_CHAR: r_out_char <= r_ch;
                ifp_pkg::EMIT_TOP:  r_out_char <= r_top;
                default:            r_out_char <= 8'd0;
            endcase
            r_term <= i_cmd.term;
            r_ovf  <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.is_end     = r_end;
        o_status.is_letter  = (r_ch >= ifp_pkg::C_LOWER_A && r_ch <= ifp_pkg::C_LOWER_Z)
                           || (r_ch >= ifp_pkg::C_UPPER_A && r_ch <= ifp_pkg::C_UPPER_Z);
        o_status.is_lparen  = (r_ch == ifp_pkg::C_LPAREN);
        o_status.is_rparen  = (r_ch == ifp_pkg::C_RPAREN);
        o_status.empty      = (r_count == '0);
        o_status.full       = (r_count >= DEPTH_C);
        o_status.top_lparen = (r_top == ifp_pkg::C_LPAREN);
        o_status.pop_ok     = (ifp_pkg::prec_of(r_top) >= ifp_pkg::prec_of(r_ch));
        o_status.can_emit   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_terminator = r_term;
    assign o_overflow   = r_ovf;

endmodule
